@@ hw/rtl/pprd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pprd_pkg
// shared types and constants of the packed pattern row decoder
// ----------------------------------------------------------------------------
package pprd_pkg;

  localparam int unsigned ChanW  = 4;
  localparam int unsigned RowW   = 6;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned FlagsW = 15;

  localparam logic [ByteW-1:0] NoneByte = 8'hff;

  // sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_TAKE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_EMIT = 4'b0100,
    ST_ERR  = 4'b1000
  } state_e;

  // stream parse phases, one-hot
  typedef enum logic [4:0] {
    PH_CNT_LO = 5'b00001,
    PH_CNT_HI = 5'b00010,
    PH_FLAG   = 5'b00100,
    PH_FIELDS = 5'b01000,
    PH_ARG    = 5'b10000
  } phase_e;

  // byte slots of one channel entry
  typedef enum logic [2:0] {
    SLOT_NOTE  = 3'd0,
    SLOT_INSTR = 3'd1,
    SLOT_VOL   = 3'd2,
    SLOT_CMD   = 3'd3,
    SLOT_ARG   = 3'd4
  } slot_e;

  typedef struct packed {
    logic [ByteW-1:0] note_code;
    logic [ByteW-1:0] instrument;
    logic [ByteW-1:0] volume;
    logic [ByteW-1:0] command;
    logic [ByteW-1:0] argument;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [ChanW-1:0] chan;
    slot_e            slot;
    logic [ByteW-1:0] data;
  } store_wr_t;

endpackage

@@ hw/rtl/pprd_row_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pprd_row_store
// per-channel entry store of the current row, byte writable, all ones at rest
// ----------------------------------------------------------------------------
module pprd_row_store #(
  parameter int unsigned CHANNELS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pprd_pkg::store_wr_t           wr_i,
  input  logic                          clr_i,
  input  logic [pprd_pkg::ChanW-1:0]    rd_chan_i,
  output pprd_pkg::entry_t              rd_entry_o
);

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  pprd_pkg::entry_t entry_q [CHANNELS];
  logic             wr_hit;

  // channels past the configured count are consumed but not kept
  assign wr_hit = wr_i.en &&
                  ({1'b0, wr_i.chan} < (pprd_pkg::ChanW + 1)'(CHANNELS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        entry_q[i] <= '1;
      end
    end else if (clr_i) begin
      for (int i = 0; i < CHANNELS; i++) begin
        entry_q[i] <= '1;
      end
    end else if (wr_hit) begin
      unique case (wr_i.slot)
        pprd_pkg::SLOT_NOTE:  entry_q[wr_i.chan[IdxW-1:0]].note_code  <= wr_i.data;
        pprd_pkg::SLOT_INSTR: entry_q[wr_i.chan[IdxW-1:0]].instrument <= wr_i.data;
        pprd_pkg::SLOT_VOL:   entry_q[wr_i.chan[IdxW-1:0]].volume     <= wr_i.data;
        pprd_pkg::SLOT_CMD:   entry_q[wr_i.chan[IdxW-1:0]].command    <= wr_i.data;
        pprd_pkg::SLOT_ARG:   entry_q[wr_i.chan[IdxW-1:0]].argument   <= wr_i.data;
        default: ;
      endcase
    end
  end

  assign rd_entry_o = entry_q[rd_chan_i[IdxW-1:0]];

endmodule

@@ hw/rtl/packed_pattern_row_decoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_pattern_row_decoder_core
// parses a packed pattern byte stream and emits one transaction per channel
// entry at each row end
// ----------------------------------------------------------------------------
// usage:
//  - input channel (in_valid_i/in_ready_o) carries one stream byte, or an
//    end-of-data marker, per transaction
//  - output channel (out_valid_o/out_ready_i) carries channel entries of a
//    finished row, or a single error transaction
//  - every input byte is captured in ST_TAKE and parsed in ST_EXEC; in_ready_o
//    is low while the byte is parsed
//  - a zero flag byte starts a row sweep: CHANNELS output transactions, one
//    per cycle at best, read from the row store by the sweep counter; input
//    is held off until the last entry sits in the output register
//  - an error passes through ST_ERR, which waits for a free output slot
//  - a stalled receiver simply holds the output register and the sweep;
//    bytes keep being accepted while a result waits, except in a sweep or error
//  - reset: parser waits for the count low byte, row store reads all ones,
//    output register empty
// ----------------------------------------------------------------------------
module packed_pattern_row_decoder_core #(
  parameter int unsigned CHANNELS = 16,
  parameter int unsigned ROWS     = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // byte stream in
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       no_more_data_i,
  // entries out
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       status_o,
  output logic [3:0] channel_o,
  output logic [5:0] row_number_o,
  output logic [7:0] note_code_o,
  output logic [7:0] instrument_o,
  output logic [7:0] volume_o,
  output logic [7:0] command_o,
  output logic [7:0] argument_o,
  output logic       last_of_row_o,
  output logic       pattern_done_o
);

  localparam logic [pprd_pkg::ChanW-1:0] LastChan = pprd_pkg::ChanW'(CHANNELS - 1);
  localparam logic [pprd_pkg::RowW-1:0]  LastRow  = pprd_pkg::RowW'(ROWS - 1);

  // sequencer and parser state
  pprd_pkg::state_e state_q, state_d;
  pprd_pkg::phase_e phase_q, phase_d;
  logic [3:0]                    pend_q, pend_d;
  logic [pprd_pkg::ChanW-1:0]    chan_q, chan_d;
  logic [pprd_pkg::RowW-1:0]     row_q, row_d;
  logic [pprd_pkg::FlagsW-1:0]   flags_left_q, flags_left_d;
  logic [7:0]                    count_low_q, count_low_d;
  logic [pprd_pkg::ChanW-1:0]    sweep_q, sweep_d;

  // captured input transaction
  logic [7:0] byte_q;
  logic       end_q;

  // output register
  logic                       out_valid_q, out_valid_d;
  logic                       status_q;
  logic [pprd_pkg::ChanW-1:0] channel_q;
  logic [pprd_pkg::RowW-1:0]  row_out_q;
  pprd_pkg::entry_t           entry_out_q;
  logic                       last_q, done_q;

  // store interface
  pprd_pkg::store_wr_t store_wr;
  logic                store_clr;
  pprd_pkg::entry_t    store_rd;

  logic in_fire, slot_free, load_row, load_err, sweep_last, last_row;

  assign in_ready_o = (state_q == pprd_pkg::ST_TAKE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign sweep_last = (sweep_q == LastChan);
  assign last_row   = (row_q == LastRow);

  pprd_row_store #(
    .CHANNELS (CHANNELS)
  ) u_row_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (store_wr),
    .clr_i      (store_clr),
    .rd_chan_i  (sweep_q),
    .rd_entry_o (store_rd)
  );

  // sequencer: capture, parse, row sweep, error hand-off
  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    pend_d       = pend_q;
    chan_d       = chan_q;
    row_d        = row_q;
    flags_left_d = flags_left_q;
    count_low_d  = count_low_q;
    sweep_d      = sweep_q;
    store_wr     = '{en: 1'b0, chan: chan_q, slot: pprd_pkg::SLOT_NOTE, data: byte_q};
    store_clr    = 1'b0;
    load_row     = 1'b0;
    load_err     = 1'b0;

    unique case (state_q)
      pprd_pkg::ST_TAKE: begin
        if (in_fire) begin
          state_d = pprd_pkg::ST_EXEC;
        end
      end

      pprd_pkg::ST_EXEC: begin
        state_d = pprd_pkg::ST_TAKE;
        if (end_q) begin
          // end of data only matters inside a pattern
          if (phase_q != pprd_pkg::PH_CNT_LO) begin
            state_d = pprd_pkg::ST_ERR;
          end
        end else begin
          unique case (phase_q)
            pprd_pkg::PH_CNT_LO: begin
              count_low_d = byte_q;
              phase_d     = pprd_pkg::PH_CNT_HI;
            end
            pprd_pkg::PH_CNT_HI: begin
              // negative count allows no flags
              flags_left_d = byte_q[7] ? '0 : {byte_q[6:0], count_low_q};
              row_d        = '0;
              phase_d      = pprd_pkg::PH_FLAG;
            end
            pprd_pkg::PH_FLAG: begin
              if (flags_left_q == '0) begin
                state_d = pprd_pkg::ST_ERR;
              end else begin
                flags_left_d = flags_left_q - pprd_pkg::FlagsW'(1);
                if (byte_q == 8'h00) begin
                  state_d = pprd_pkg::ST_EMIT;
                  sweep_d = '0;
                end else begin
                  chan_d = byte_q[3:0];
                  pend_d = byte_q[7:4];
                  if (byte_q[7:4] != 4'h0) begin
                    phase_d = pprd_pkg::PH_FIELDS;
                  end
                end
              end
            end
            pprd_pkg::PH_FIELDS: begin
              store_wr.en = 1'b1;
              priority if (pend_q[3]) begin
                store_wr.slot = pprd_pkg::SLOT_NOTE;
                pend_d        = {1'b0, pend_q[2:0]};
              end else if (pend_q[2]) begin
                store_wr.slot = pprd_pkg::SLOT_INSTR;
                pend_d        = {2'b00, pend_q[1:0]};
              end else if (pend_q[1]) begin
                store_wr.slot = pprd_pkg::SLOT_VOL;
                pend_d        = {3'b000, pend_q[0]};
              end else begin
                store_wr.slot = pprd_pkg::SLOT_CMD;
                pend_d        = 4'h0;
              end
              if (!pend_q[3] && !pend_q[2] && !pend_q[1]) begin
                phase_d = pprd_pkg::PH_ARG;
              end else if (pend_d == 4'h0) begin
                phase_d = pprd_pkg::PH_FLAG;
              end
            end
            pprd_pkg::PH_ARG: begin
              store_wr.en   = 1'b1;
              store_wr.slot = pprd_pkg::SLOT_ARG;
              phase_d       = pprd_pkg::PH_FLAG;
            end
            default: phase_d = pprd_pkg::PH_CNT_LO;
          endcase
        end
      end

      pprd_pkg::ST_EMIT: begin
        // one entry per free output slot
        if (slot_free) begin
          load_row = 1'b1;
          sweep_d  = sweep_q + pprd_pkg::ChanW'(1);
          if (sweep_last) begin
            store_clr = 1'b1;
            sweep_d   = '0;
            state_d   = pprd_pkg::ST_TAKE;
            if (last_row) begin
              row_d   = '0;
              phase_d = pprd_pkg::PH_CNT_LO;
            end else begin
              row_d = row_q + pprd_pkg::RowW'(1);
            end
          end
        end
      end

      pprd_pkg::ST_ERR: begin
        if (slot_free) begin
          // error transaction, then full parser reset
          load_err     = 1'b1;
          store_clr    = 1'b1;
          phase_d      = pprd_pkg::PH_CNT_LO;
          pend_d       = 4'h0;
          chan_d       = '0;
          row_d        = '0;
          flags_left_d = '0;
          count_low_d  = '0;
          state_d      = pprd_pkg::ST_TAKE;
        end
      end

      default: state_d = pprd_pkg::ST_TAKE;
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_row || load_err) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pprd_pkg::ST_TAKE;
      phase_q      <= pprd_pkg::PH_CNT_LO;
      pend_q       <= 4'h0;
      chan_q       <= '0;
      row_q        <= '0;
      flags_left_q <= '0;
      count_low_q  <= '0;
      sweep_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      pend_q       <= pend_d;
      chan_q       <= chan_d;
      row_q        <= row_d;
      flags_left_q <= flags_left_d;
      count_low_q  <= count_low_d;
      sweep_q      <= sweep_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // captured byte, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      byte_q <= data_byte_i;
      end_q  <= no_more_data_i;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load_row) begin
      status_q    <= 1'b0;
      channel_q   <= sweep_q;
      row_out_q   <= row_q;
      entry_out_q <= store_rd;
      last_q      <= sweep_last;
      done_q      <= sweep_last && last_row;
    end else if (load_err) begin
      status_q    <= 1'b1;
      channel_q   <= '0;
      row_out_q   <= row_q;
      entry_out_q <= '{default: pprd_pkg::NoneByte};
      last_q      <= 1'b1;
      done_q      <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign channel_o      = channel_q;
  assign row_number_o   = row_out_q;
  assign note_code_o    = entry_out_q.note_code;
  assign instrument_o   = entry_out_q.instrument;
  assign volume_o       = entry_out_q.volume;
  assign command_o      = entry_out_q.command;
  assign argument_o     = entry_out_q.argument;
  assign last_of_row_o  = last_q;
  assign pattern_done_o = done_q;

`ifndef SYNTHESIS
  // a captured byte is always parsed before the next one is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == pprd_pkg::ST_EXEC) && !in_ready_o)
    else $error("byte accepted without a parse cycle");

  // pattern end only on the last entry of a good row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && pattern_done_o) |-> (last_of_row_o && !status_o))
    else $error("pattern_done on a non-final or error entry");

  // error transactions close the row and carry channel zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (last_of_row_o && (channel_o == '0)))
    else $error("malformed error transaction");

  // the row sweep never runs past the configured channel count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pprd_pkg::ST_EMIT) |-> ({1'b0, sweep_q} < 5'(CHANNELS)))
    else $error("row sweep out of range");
`endif

endmodule
